@@ sv/dpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_pkg
// Types, character codes and the hex digit decoder shared by the debug
// packet deframer modules.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam logic [7:0] CH_ACK   = 8'h2b;  // '+'
  localparam logic [7:0] CH_NACK  = 8'h2d;  // '-'
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_D0    = 8'h30;  // '0'
  localparam logic [7:0] CH_D9    = 8'h39;  // '9'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_FRAME   = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_OK      = 3'd2,
    EV_BAD     = 3'd3,
    EV_ACK     = 3'd4,
    EV_STRAY   = 3'd5
  } event_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_sum;
    logic [3:0] high_nibble;
    logic       hex_error_seen;
  } dpd_state_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] payload;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [7:0] computed_sum;
    logic       bad_hex;
  } dpd_result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one hex digit; a non-hex byte reads as zero with bad set.
  function automatic hex_digit_t hex_decode(input logic [7:0] ch);
    hex_digit_t d;
    logic [7:0] v;
    d = '{bad: 1'b0, value: 4'd0};
    v = 8'd0;
    if (ch inside {[CH_D0:CH_D9]}) begin
      v = ch - CH_D0;
    end else if (ch inside {[CH_LA:CH_LF]}) begin
      v = ch - CH_LA + HEX_TEN;
    end else if (ch inside {[CH_UA:CH_UF]}) begin
      v = ch - CH_UA + HEX_TEN;
    end else begin
      d.bad = 1'b1;
    end
    d.value = v[3:0];
    return d;
  endfunction

endpackage
`default_nettype wire

@@ sv/dpd_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpd_step
// Framing decision for one received byte: next framing state and the
// result of the byte.
// ----------------------------------------------------------------------------
module dpd_step (
  input  wire logic [7:0]          rx_byte,
  input  wire dpd_pkg::dpd_state_t st,
  output dpd_pkg::dpd_state_t      st_next,
  output dpd_pkg::dpd_result_t     res
);
  import dpd_pkg::*;

  hex_digit_t digit;
  logic [7:0] recv;
  logic       match;

  assign digit = hex_decode(rx_byte);
  assign recv  = {st.high_nibble, digit.value};
  assign match = (recv == st.running_sum);

  always_comb begin
    st_next = st;
    res     = '{event_res: EV_FRAME, payload: 8'd0, send_valid: 1'b0,
                send_byte: 8'd0, computed_sum: 8'd0, bad_hex: 1'b0};
    case (st.phase)
      PH_IDLE: begin
        if (rx_byte == CH_ACK) begin
          res.event_res = EV_ACK;
        end else if (rx_byte == CH_START) begin
          st_next = '{phase: PH_DATA, running_sum: 8'd0, high_nibble: 4'd0,
                      hex_error_seen: 1'b0};
        end else begin
          res.event_res = EV_STRAY;
        end
      end
      PH_DATA: begin
        if (rx_byte == CH_END) begin
          st_next.phase = PH_HIGH;
        end else begin
          res.event_res       = EV_PAYLOAD;
          res.payload         = rx_byte;
          st_next.running_sum = st.running_sum + rx_byte;
        end
      end
      PH_HIGH: begin
        st_next.high_nibble    = digit.value;
        st_next.hex_error_seen = digit.bad;
        st_next.phase          = PH_LOW;
      end
      PH_LOW: begin
        res.event_res    = match ? EV_OK : EV_BAD;
        res.send_valid   = 1'b1;
        res.send_byte    = match ? CH_ACK : CH_NACK;
        res.computed_sum = st.running_sum;
        res.bad_hex      = st.hex_error_seen | digit.bad;
        st_next = '{phase: PH_IDLE, running_sum: 8'd0, high_nibble: 4'd0,
                    hex_error_seen: 1'b0};
      end
      default: begin
        st_next.phase = PH_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/debug_packet_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Receive side of a debugger remote serial link: splits the byte stream into
// acknowledges, stray bytes and '$'...'#xx' packets, forwards payload bytes
// and checks the two-digit hex checksum.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | fields
//  --------+---------------------+---------------------------------------------
//  input   | in_valid / in_stall | rx_byte
//  output  | out_valid/out_stall | event_res, payload, send_valid, send_byte,
//          |                     | computed_sum, bad_hex
//
//  One byte per cycle sustained while out_stall stays low; each transaction
//  passes through the input register, then the result register.
//  The state is updated when a byte moves from the input register into the
//  result register, so back-to-back bytes see each other's effect in order.
//  A stalled result holds; the input register then holds too and in_stall
//  rises only while both stages are occupied.
//  Reset returns to idle outside a packet with both stages empty.
//
module debug_packet_deframer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          rx_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dpd_pkg::event_t          event_res,
  output logic [7:0]               payload,
  output logic                     send_valid,
  output logic [7:0]               send_byte,
  output logic [7:0]               computed_sum,
  output logic                     bad_hex
);
  import dpd_pkg::*;

  // input register stage
  logic        s1_valid;
  logic [7:0]  s1_byte;

  // framing state
  dpd_state_t  st;
  dpd_state_t  st_next;
  dpd_result_t res_next;

  logic out_free;
  logic advance;
  logic accept_in;

  // Result register empties or drains this cycle.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign accept_in = in_valid && !in_stall;

  dpd_step u_step (
    .rx_byte (s1_byte),
    .st      (st),
    .st_next (st_next),
    .res     (res_next)
  );

  // Hold the byte until the result register can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_byte <= rx_byte;
    end
  end

  // Advance the framing state only with the transaction that causes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, running_sum: 8'd0, high_nibble: 4'd0,
              hex_error_seen: 1'b0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res    <= res_next.event_res;
      payload      <= res_next.payload;
      send_valid   <= res_next.send_valid;
      send_byte    <= res_next.send_byte;
      computed_sum <= res_next.computed_sum;
      bad_hex      <= res_next.bad_hex;
    end
  end

`ifndef SYNTHESIS
  // A closing result always leaves the receiver idle outside a packet.
  a_close_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_OK || event_res == EV_BAD) |-> st.phase == PH_IDLE)
    else $error("closing event without return to idle");

  // A reply byte goes out exactly on the closing events.
  a_send_close: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> send_valid == (event_res == EV_OK || event_res == EV_BAD))
    else $error("send_valid disagrees with event");

  // A payload result only follows a byte taken inside a packet.
  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.event_res == EV_PAYLOAD |=> st.phase == PH_DATA)
    else $error("payload event outside packet body");

  // Upstream stalls only while the input register is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("stall raised with room to advance");
`endif

endmodule
`default_nettype wire
